>>> sv/msiva_pkg.sv
`default_nettype none

package msiva_pkg;

	// Field widths of the request and result beats
	localparam int CMD_W     = 2;
	localparam int COUNT_W   = 9;
	localparam int VECTOR_W  = 12;
	localparam int CPU_W     = 3;
	localparam int ADDR_W    = 56;
	localparam int STATUS_W  = 2;
	localparam int DATA_W    = 9;
	localparam int FV_W      = 11;
	localparam int VC_W      = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 11;

	// Range checks run at this width so no sum or difference can wrap
	localparam int CMP_W = 13;

	localparam logic [VC_W-1:0] VECTOR_COUNT_RST = 9'd256;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd2;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_VECTOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_COUNT = 1'd1;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [COUNT_W-1:0]  count;
		logic [VECTOR_W-1:0] vector;
		logic [CPU_W-1:0]    cpu;
		logic [ADDR_W-1:0]   cpu_address;
	} msiva_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VECTOR_W-1:0] start_vector;
		logic [ADDR_W-1:0]   message_address;
		logic [DATA_W-1:0]   message_data;
		logic [CPU_W-1:0]    assigned_cpu;
	} msiva_out_t;

	// One allocation entry held by a ring cell
	typedef struct packed {
		logic             busy;
		logic [CPU_W-1:0] cpu;
	} msiva_entry_t;

	// Change applied to the entry entering the tail cell
	typedef struct packed {
		logic             set_busy;
		logic             clr_busy;
		logic             wr_cpu;
		logic [CPU_W-1:0] cpu;
	} msiva_edit_t;

	localparam msiva_edit_t EDIT_NONE = '{set_busy: 1'b0, clr_busy: 1'b0, wr_cpu: 1'b0,
		cpu: 3'd0};

	typedef struct packed {
		logic        shift;
		msiva_edit_t edit;
	} msiva_ring_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_EDIT,
		S_DONE
	} msiva_state_t;

endpackage

`default_nettype wire

>>> sv/msiva_cell.sv
`default_nettype none

module msiva_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     shift,
	input  msiva_pkg::msiva_edit_t  edit,
	input  msiva_pkg::msiva_entry_t nxt,
	output msiva_pkg::msiva_entry_t ent
);

	msiva_pkg::msiva_entry_t upd;
	msiva_pkg::msiva_entry_t ent_q;

	// Apply the edit to the entry coming from the neighbor
	always_comb begin
		upd = nxt;
		if (edit.set_busy) begin
			upd.busy = 1'b1;
		end
		if (edit.clr_busy) begin
			upd.busy = 1'b0;
		end
		if (edit.wr_cpu) begin
			upd.cpu = edit.cpu;
		end
	end

	// Take the neighbor's entry on every shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (shift) begin
			ent_q <= upd;
		end
	end

	assign ent = ent_q;

endmodule

`default_nettype wire

>>> sv/msiva_ctrl.sv
`default_nettype none

module msiva_ctrl #(
	parameter int VECTOR_ENTRIES = 256,
	parameter int CPU_COUNT      = 8
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  msiva_pkg::msiva_in_t                   in_data,
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output msiva_pkg::msiva_out_t                  out_data,
	input  wire  [msiva_pkg::FV_W-1:0]             first_vector,
	input  wire  [msiva_pkg::VC_W-1:0]             vector_count,
	input  msiva_pkg::msiva_entry_t                head,
	output msiva_pkg::msiva_ring_ctl_t             ring_ctl
);

	localparam int IDX_W     = (VECTOR_ENTRIES > 1) ? $clog2(VECTOR_ENTRIES) : 1;
	localparam int CNT_W     = $clog2(VECTOR_ENTRIES + 1);
	localparam int CPU_DEPTH = (CPU_COUNT < 8) ? CPU_COUNT : 8;
	localparam int CPU_IW    = (CPU_DEPTH > 1) ? $clog2(CPU_DEPTH) : 1;
	localparam int CW        = msiva_pkg::CMP_W;
	localparam int VW        = msiva_pkg::VECTOR_W;
	localparam int DW        = msiva_pkg::DATA_W;
	localparam int AW        = msiva_pkg::ADDR_W;
	localparam int CPW       = msiva_pkg::CPU_W;
	localparam int CTW       = msiva_pkg::COUNT_W;
	localparam int CMW       = msiva_pkg::CMD_W;

	localparam logic [IDX_W-1:0] LAST_POS  = IDX_W'(VECTOR_ENTRIES - 1);
	localparam logic [CW-1:0]    ENTRIES_W = CW'(VECTOR_ENTRIES);
	localparam logic [CW-1:0]    CPUS_W    = CW'(CPU_COUNT);
	localparam logic [CW-1:0]    ONE_W     = CW'(1);

	msiva_pkg::msiva_state_t state_q, state_n;
	logic [IDX_W-1:0]        pos_q, pos_n;
	logic [CNT_W-1:0]        run_q, run_n;
	logic                    found_q, found_n;
	logic [IDX_W-1:0]        start_q, start_n;
	logic [IDX_W-1:0]        idx_q, idx_n;
	logic [CTW-1:0]          cnt_q, cnt_n;
	logic [CPW-1:0]          cpu_q, cpu_n;
	logic [CMW-1:0]          op_q, op_n;
	msiva_pkg::msiva_out_t   res_q, res_n;
	msiva_pkg::msiva_out_t   out_q, out_n;
	logic                    out_valid_q, out_valid_n;
	logic [AW-1:0]           addr_tbl_q [CPU_DEPTH];
	logic                    tbl_we;

	logic [CW-1:0] vc_w, depth_w, fv_w, vec_w, cntin_w, cpuin_w, rel_w;
	logic [CW-1:0] pos_w, start_w, idx_w, cnt_w;
	logic          last;

	// Widen operands for the range checks
	always_comb begin
		vc_w    = CW'(vector_count);
		depth_w = (vc_w < ENTRIES_W) ? vc_w : ENTRIES_W;
		fv_w    = CW'(first_vector);
		vec_w   = CW'(in_data.vector);
		cntin_w = CW'(in_data.count);
		cpuin_w = CW'(in_data.cpu);
		rel_w   = vec_w - fv_w;
		pos_w   = CW'(pos_q);
		start_w = CW'(start_q);
		idx_w   = CW'(idx_q);
		cnt_w   = CW'(cnt_q);
		last    = (pos_q == LAST_POS);
	end

	assign in_stall = (state_q != msiva_pkg::S_IDLE);

	// Next state, walk counters and result
	always_comb begin
		state_n     = state_q;
		pos_n       = pos_q;
		run_n       = run_q;
		found_n     = found_q;
		start_n     = start_q;
		idx_n       = idx_q;
		cnt_n       = cnt_q;
		cpu_n       = cpu_q;
		op_n        = op_q;
		res_n       = res_q;
		out_n       = out_q;
		out_valid_n = out_valid_q;
		tbl_we      = 1'b0;
		ring_ctl    = '{shift: 1'b0, edit: msiva_pkg::EDIT_NONE};

		// drop the result once it is taken
		if (out_valid_q && !out_stall) begin
			out_valid_n = 1'b0;
		end

		case (state_q)
			msiva_pkg::S_IDLE: begin
				if (in_valid) begin
					res_n        = '0;
					res_n.status = msiva_pkg::STATUS_RANGE;
					state_n      = msiva_pkg::S_DONE;
					op_n         = in_data.command;
					cnt_n        = in_data.count;
					cpu_n        = in_data.cpu;
					idx_n        = rel_w[IDX_W-1:0];
					pos_n        = '0;
					run_n        = '0;
					found_n      = 1'b0;
					case (in_data.command)
						msiva_pkg::CMD_ALLOC: begin
							if (cntin_w != '0 && cntin_w <= depth_w) begin
								state_n = msiva_pkg::S_SCAN;
							end
						end
						msiva_pkg::CMD_FREE: begin
							if (cntin_w != '0 && vec_w >= fv_w && rel_w < depth_w &&
								cntin_w <= depth_w - rel_w) begin
								state_n = msiva_pkg::S_EDIT;
							end
						end
						msiva_pkg::CMD_ASSIGN: begin
							if (vec_w >= fv_w && cpuin_w < CPUS_W && rel_w < depth_w) begin
								state_n = msiva_pkg::S_EDIT;
							end
						end
						msiva_pkg::CMD_LOAD: begin
							if (cpuin_w < CPUS_W) begin
								tbl_we       = 1'b1;
								res_n.status = msiva_pkg::STATUS_OK;
							end
						end
						default: begin
						end
					endcase
				end
			end

			msiva_pkg::S_SCAN: begin
				// track the run of clear entries passing the head
				ring_ctl.shift = 1'b1;
				pos_n = last ? '0 : pos_q + IDX_W'(1);
				if (!found_q && pos_w < depth_w) begin
					if (head.busy) begin
						run_n = '0;
					end else begin
						run_n = run_q + CNT_W'(1);
						if (CW'(run_q) + ONE_W == cnt_w) begin
							found_n = 1'b1;
							start_n = IDX_W'(pos_w + ONE_W - cnt_w);
						end
					end
				end
				if (last) begin
					if (found_n) begin
						state_n = msiva_pkg::S_MARK;
					end else begin
						res_n.status = msiva_pkg::STATUS_NO_ROOM;
						state_n      = msiva_pkg::S_DONE;
					end
				end
			end

			msiva_pkg::S_MARK: begin
				// mark the found run and pick up the target of its first entry
				ring_ctl.shift = 1'b1;
				ring_ctl.edit.set_busy = (pos_w >= start_w) && (pos_w < start_w + cnt_w);
				pos_n = last ? '0 : pos_q + IDX_W'(1);
				if (pos_q == start_q) begin
					res_n.message_address = addr_tbl_q[head.cpu[CPU_IW-1:0]];
				end
				if (last) begin
					res_n.status       = msiva_pkg::STATUS_OK;
					res_n.start_vector = VW'(fv_w + start_w);
					res_n.message_data = DW'(start_w + ONE_W);
					state_n            = msiva_pkg::S_DONE;
				end
			end

			msiva_pkg::S_EDIT: begin
				// clear a run or rewrite one entry's target as it passes
				ring_ctl.shift = 1'b1;
				if (op_q == msiva_pkg::CMD_FREE) begin
					ring_ctl.edit.clr_busy = (pos_w >= idx_w) && (pos_w < idx_w + cnt_w);
				end else begin
					ring_ctl.edit.wr_cpu = (pos_q == idx_q);
					ring_ctl.edit.cpu    = cpu_q;
				end
				pos_n = last ? '0 : pos_q + IDX_W'(1);
				if (last) begin
					res_n.status = msiva_pkg::STATUS_OK;
					if (op_q == msiva_pkg::CMD_ASSIGN) begin
						res_n.assigned_cpu = cpu_q;
					end
					state_n = msiva_pkg::S_DONE;
				end
			end

			msiva_pkg::S_DONE: begin
				// hand the result to the output register once it is free
				if (!out_valid_q || !out_stall) begin
					out_n       = res_q;
					out_valid_n = 1'b1;
					state_n     = msiva_pkg::S_IDLE;
				end
			end

			default: begin
				state_n = msiva_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msiva_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= out_valid_n;
			found_q     <= found_n;
		end
	end

	// Walk and result payload
	always_ff @(posedge clk) begin
		pos_q   <= pos_n;
		run_q   <= run_n;
		start_q <= start_n;
		idx_q   <= idx_n;
		cnt_q   <= cnt_n;
		cpu_q   <= cpu_n;
		op_q    <= op_n;
		res_q   <= res_n;
		out_q   <= out_n;
	end

	// Per-cpu message address table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CPU_DEPTH; k++) begin
				addr_tbl_q[k] <= '0;
			end
		end else if (tbl_we) begin
			addr_tbl_q[in_data.cpu[CPU_IW-1:0]] <= in_data.cpu_address;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> sv/msi_vector_range_allocator.sv
// MSI vector range allocator.
// Requests enter on in_valid/in_stall/in_data: allocate a run of count
// vectors, free a run, assign an entry's target cpu, or load a cpu's message
// address. Each request gives exactly one result beat on
// out_valid/out_stall/out_data. The user must write registers first_vector
// and vector_count through cfg_write/cfg_index/cfg_data only while no
// request is in work; the block itself does not enforce this. The allocation
// entries sit in a ring of VECTOR_ENTRIES cells that rotates one place a
// cycle while a request walks it past the head cell. A load or a rejected
// request goes to the done step; free and assign walk one revolution;
// allocate scans one and, when a run is found, marks in another.
// One request is in work at a time; in_stall is high from accept until the
// result enters the output register. A result held by out_stall keeps its
// beat stable and the next request waits in the done step until it drains.
// Reset clears all entries to free with cpu zero, the address table to
// zero, first_vector to 0 and vector_count to 256; no sweep is needed.
`default_nettype none

module msi_vector_range_allocator #(
	parameter int VECTOR_ENTRIES = 256,
	parameter int CPU_COUNT      = 8
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  msiva_pkg::msiva_in_t                   in_data,
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output msiva_pkg::msiva_out_t                  out_data,
	input  wire                                    cfg_write,
	input  wire  [msiva_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [msiva_pkg::CFG_DAT_W-1:0]        cfg_data
);

	logic [msiva_pkg::FV_W-1:0]  first_vector_q;
	logic [msiva_pkg::VC_W-1:0]  vector_count_q;
	msiva_pkg::msiva_ring_ctl_t  ring_ctl;
	msiva_pkg::msiva_entry_t     ring_ent [VECTOR_ENTRIES];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_vector_q <= '0;
			vector_count_q <= msiva_pkg::VECTOR_COUNT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				msiva_pkg::CFG_FIRST_VECTOR: begin
					first_vector_q <= cfg_data[msiva_pkg::FV_W-1:0];
				end
				msiva_pkg::CFG_VECTOR_COUNT: begin
					vector_count_q <= cfg_data[msiva_pkg::VC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Ring of entry cells; the tail takes the edited head entry
	for (genvar gi = 0; gi < VECTOR_ENTRIES; gi++) begin : g_cell
		localparam int NXT = (gi == VECTOR_ENTRIES - 1) ? 0 : gi + 1;
		msiva_pkg::msiva_edit_t cell_edit;

		assign cell_edit = (gi == VECTOR_ENTRIES - 1) ? ring_ctl.edit : msiva_pkg::EDIT_NONE;

		msiva_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ring_ctl.shift),
			.edit   (cell_edit),
			.nxt    (ring_ent[NXT]),
			.ent    (ring_ent[gi])
		);
	end

	msiva_ctrl #(
		.VECTOR_ENTRIES (VECTOR_ENTRIES),
		.CPU_COUNT      (CPU_COUNT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.first_vector (first_vector_q),
		.vector_count (vector_count_q),
		.head         (ring_ent[0]),
		.ring_ctl     (ring_ctl)
	);

	// A request in work blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while previous one still in work");

	// A failed request carries only its status
	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != msiva_pkg::STATUS_OK) |->
		(out_data.start_vector == '0 && out_data.message_address == '0 &&
		out_data.message_data == '0 && out_data.assigned_cpu == '0))
		else $error("failed result carries nonzero payload");

	// An allocation result never echoes a cpu
	a_alloc_no_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == msiva_pkg::STATUS_OK &&
		out_data.message_data != '0) |-> (out_data.assigned_cpu == '0))
		else $error("allocation result echoes a cpu");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int CMD_W     = msiva_pkg::CMD_W;
	localparam int COUNT_W   = msiva_pkg::COUNT_W;
	localparam int VECTOR_W  = msiva_pkg::VECTOR_W;
	localparam int CPU_W     = msiva_pkg::CPU_W;
	localparam int ADDR_W    = msiva_pkg::ADDR_W;
	localparam int STATUS_W  = msiva_pkg::STATUS_W;
	localparam int DATA_W    = msiva_pkg::DATA_W;
	localparam int FV_W      = msiva_pkg::FV_W;
	localparam int VC_W      = msiva_pkg::VC_W;
	localparam int CFG_IDX_W = msiva_pkg::CFG_IDX_W;
	localparam int CFG_DAT_W = msiva_pkg::CFG_DAT_W;

	localparam int ENTRIES         = 256;
	localparam int CPUS            = 8;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 113;
	localparam int PAUSE_AT        = 50;
	localparam int HOLD_AT         = 40;
	localparam int LONG_HOLD       = 1500;
	localparam int QUIET_LIMIT     = 20000;
	localparam int END_SETTLE      = 2 * ENTRIES + 10;
	localparam bit BY_MODEL        = 1'b0;
	localparam bit TYPED           = 1'b1;

	typedef struct {
		msiva_pkg::msiva_in_t  req;
		bit                    typed;
		msiva_pkg::msiva_out_t res;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	msiva_pkg::msiva_in_t  in_data;
	logic                  out_valid;
	logic                  out_stall;
	msiva_pkg::msiva_out_t out_data;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DAT_W-1:0]  cfg_data;

	// Predictor state
	logic [FV_W-1:0]   first_vec;
	logic [VC_W-1:0]   vec_count;
	bit                busy_map [ENTRIES];
	logic [CPU_W-1:0]  entry_cpu [ENTRIES];
	logic [ADDR_W-1:0] cpu_addr [CPUS];

	msiva_pkg::msiva_out_t pending_results [$];
	directed_row_t         directed_requests [$];
	int                    live_run_base [$];
	int                    live_run_len [$];
	int                    mismatches = 0;
	int                    sent_count = 0;
	int                    hold_requests = 0;
	int                    quiet_cycles = 0;

	always #5 clk = ~clk;

	msi_vector_range_allocator #(
		.VECTOR_ENTRIES(ENTRIES),
		.CPU_COUNT(CPUS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic int live_depth();
		return (int'(vec_count) < ENTRIES) ? int'(vec_count) : ENTRIES;
	endfunction

	// Apply one request to the predicted state and return its result beat
	function automatic msiva_pkg::msiva_out_t apply_request(msiva_pkg::msiva_in_t req);
		msiva_pkg::msiva_out_t res;
		int depth, idx, run, base, i;
		bit found;
		res = '0;
		res.status = msiva_pkg::STATUS_RANGE;
		depth = live_depth();
		found = 1'b0;
		run = 0;
		base = 0;
		case (req.command)
			msiva_pkg::CMD_ALLOC: begin
				if (req.count != 0 && int'(req.count) <= depth) begin
					// lowest run of clear entries wins
					for (i = 0; i < depth && !found; i++) begin
						if (busy_map[i]) begin
							run = 0;
						end else begin
							run++;
							if (run == int'(req.count)) begin
								base = i + 1 - run;
								found = 1'b1;
							end
						end
					end
					if (!found) begin
						res.status = msiva_pkg::STATUS_NO_ROOM;
					end else begin
						for (i = base; i < base + int'(req.count); i++)
							busy_map[i] = 1'b1;
						res.status = msiva_pkg::STATUS_OK;
						res.start_vector = VECTOR_W'(int'(first_vec) + base);
						res.message_data = DATA_W'(base + 1);
						res.message_address = cpu_addr[entry_cpu[base]];
					end
				end
			end
			msiva_pkg::CMD_FREE: begin
				if (req.count != 0 && req.vector >= first_vec) begin
					idx = int'(req.vector) - int'(first_vec);
					if (idx < depth && int'(req.count) <= depth - idx) begin
						for (i = idx; i < idx + int'(req.count); i++)
							busy_map[i] = 1'b0;
						res.status = msiva_pkg::STATUS_OK;
					end
				end
			end
			msiva_pkg::CMD_ASSIGN: begin
				if (req.vector >= first_vec && int'(req.cpu) < CPUS) begin
					idx = int'(req.vector) - int'(first_vec);
					if (idx < depth) begin
						entry_cpu[idx] = req.cpu;
						res.assigned_cpu = req.cpu;
						res.status = msiva_pkg::STATUS_OK;
					end
				end
			end
			default: begin
				if (int'(req.cpu) < CPUS) begin
					cpu_addr[req.cpu] = req.cpu_address;
					res.status = msiva_pkg::STATUS_OK;
				end
			end
		endcase
		return res;
	endfunction

	function automatic directed_row_t dir_row(logic [CMD_W-1:0] cmd, int cnt, int vec, int cpu,
		logic [ADDR_W-1:0] addr, bit typed, logic [STATUS_W-1:0] st, int echo);
		directed_row_t row;
		row.req.command = cmd;
		row.req.count = COUNT_W'(cnt);
		row.req.vector = VECTOR_W'(vec);
		row.req.cpu = CPU_W'(cpu);
		row.req.cpu_address = addr;
		row.typed = typed;
		row.res = '0;
		row.res.status = st;
		row.res.assigned_cpu = CPU_W'(echo);
		return row;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Compare a result beat with the oldest expectation, field by field
	task automatic check_result(msiva_pkg::msiva_out_t got);
		msiva_pkg::msiva_out_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result beat with no request outstanding");
		end else begin
			want = pending_results.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status want %0d got %0d", want.status, got.status));
			if (got.start_vector !== want.start_vector)
				report_mismatch($sformatf("start_vector want %0d got %0d",
					want.start_vector, got.start_vector));
			if (got.message_address !== want.message_address)
				report_mismatch($sformatf("message_address want %h got %h",
					want.message_address, got.message_address));
			if (got.message_data !== want.message_data)
				report_mismatch($sformatf("message_data want %0d got %0d",
					want.message_data, got.message_data));
			if (got.assigned_cpu !== want.assigned_cpu)
				report_mismatch($sformatf("assigned_cpu want %0d got %0d",
					want.assigned_cpu, got.assigned_cpu));
		end
	endtask

	// Offer one request beat, record its expectation, then idle a random gap, possibly none
	task automatic send_request(input msiva_pkg::msiva_in_t req, input bit typed,
		input msiva_pkg::msiva_out_t typed_res, input bit go_quiet,
		output msiva_pkg::msiva_out_t model_res);
		int gap, p;
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		model_res = apply_request(req);
		pending_results.push_back(typed ? typed_res : model_res);
		sent_count++;
		p = $urandom_range(99);
		if (((sent_count / 48) % 4) == 2)
			gap = 0;
		else if (p < 55)
			gap = 0;
		else if (p < 88)
			gap = $urandom_range(1, 3);
		else if (p < 98)
			gap = $urandom_range(4, 20);
		else
			gap = $urandom_range(60, 200);
		if (go_quiet && gap == 0)
			gap = 1;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold until every result has drained and the block takes requests again
	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Write both registers on back-to-back edges
	task automatic write_regs(logic [CFG_DAT_W-1:0] fv_word, logic [CFG_DAT_W-1:0] vc_word);
		cfg_write <= 1'b1;
		cfg_index <= msiva_pkg::CFG_FIRST_VECTOR;
		cfg_data <= fv_word;
		@(posedge clk);
		first_vec = fv_word[FV_W-1:0];
		cfg_index <= msiva_pkg::CFG_VECTOR_COUNT;
		cfg_data <= vc_word;
		@(posedge clk);
		vec_count = vc_word[VC_W-1:0];
		cfg_write <= 1'b0;
	endtask

	// Mostly well-formed requests against tracked runs, the rest noise
	task automatic make_request(output msiva_pkg::msiva_in_t req);
		int depth, pick, slot;
		depth = live_depth();
		pick = $urandom_range(99);
		req.command = CMD_W'($urandom);
		req.count = COUNT_W'($urandom);
		req.vector = VECTOR_W'($urandom);
		req.cpu = CPU_W'($urandom);
		req.cpu_address = ADDR_W'({$urandom, $urandom});
		if (pick >= 12 && depth > 0) begin
			if (pick < 45 || (pick < 75 && live_run_base.size() == 0)) begin
				req.command = msiva_pkg::CMD_ALLOC;
				if ($urandom_range(9) == 0)
					req.count = COUNT_W'($urandom_range(1, depth));
				else
					req.count = COUNT_W'($urandom_range(1, (depth < 8) ? depth : 8));
			end else if (pick < 75) begin
				slot = $urandom_range(live_run_base.size() - 1);
				req.command = msiva_pkg::CMD_FREE;
				req.vector = VECTOR_W'(int'(first_vec) + live_run_base[slot]);
				req.count = COUNT_W'(live_run_len[slot]);
				live_run_base.delete(slot);
				live_run_len.delete(slot);
			end else if (pick < 90) begin
				req.command = msiva_pkg::CMD_ASSIGN;
				req.vector = VECTOR_W'(int'(first_vec) + $urandom_range(0, depth - 1));
			end else if (pick < 97) begin
				req.command = msiva_pkg::CMD_LOAD;
			end else begin
				req.command = msiva_pkg::CMD_FREE;
				req.vector = VECTOR_W'(first_vec);
				req.count = COUNT_W'(depth);
				live_run_base.delete();
				live_run_len.delete();
			end
		end
	endtask

	// Result side: check accepted beats, stall at random
	initial begin : result_side
		int p, stall_left, holds_started, rx_cycle;
		stall_left = 0;
		holds_started = 0;
		rx_cycle = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (out_valid && !out_stall)
				check_result(out_data);
			if (holds_started != hold_requests) begin
				holds_started++;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				p = $urandom_range(99);
				if (((rx_cycle / 900) % 3) == 1 || p < 50)
					stall_left = 0;
				else if (p < 90)
					stall_left = $urandom_range(1, 4);
				else if (p < 98)
					stall_left = $urandom_range(5, 30);
				else
					stall_left = $urandom_range(100, 400);
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Request side and run control
	initial begin : request_side
		msiva_pkg::msiva_in_t  req;
		msiva_pkg::msiva_out_t model_res;
		int                    ph, k, r, fv_pick, vc_pick;
		bit                    pause_here;
		static int             phase_fv [PHASES] = '{0, 2047, 0, 1500, 3, -1, 2047, 0, -1, 1};
		static int             phase_vc [PHASES] = '{256, 256, 1, 'h600, 'h7FF, -1, 1, 255, -1,
			256};

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		first_vec = '0;
		vec_count = msiva_pkg::VECTOR_COUNT_RST;
		foreach (busy_map[i]) begin
			busy_map[i] = 1'b0;
			entry_cpu[i] = '0;
		end
		foreach (cpu_addr[i])
			cpu_addr[i] = '0;

		// Opening requests at reset settings: extremes, every command, each reject
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ALLOC, 0, 0, 0, '0, TYPED,
			msiva_pkg::STATUS_RANGE, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ALLOC, 257, 0, 0, '0, TYPED,
			msiva_pkg::STATUS_RANGE, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ALLOC, 511, 4095, 7, '1, TYPED,
			msiva_pkg::STATUS_RANGE, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_LOAD, 0, 0, 7, '1, TYPED,
			msiva_pkg::STATUS_OK, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_LOAD, 0, 0, 0, 56'h00A5_5A0F_F00F_1234,
			TYPED, msiva_pkg::STATUS_OK, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ASSIGN, 0, 0, 7, '0, TYPED,
			msiva_pkg::STATUS_OK, 7));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ALLOC, 1, 0, 0, '0, BY_MODEL,
			msiva_pkg::STATUS_OK, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ALLOC, 256, 0, 0, '0, TYPED,
			msiva_pkg::STATUS_NO_ROOM, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ALLOC, 255, 0, 0, '0, BY_MODEL,
			msiva_pkg::STATUS_OK, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ALLOC, 1, 0, 0, '0, TYPED,
			msiva_pkg::STATUS_NO_ROOM, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_FREE, 256, 0, 0, '0, TYPED,
			msiva_pkg::STATUS_OK, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_FREE, 257, 0, 0, '0, TYPED,
			msiva_pkg::STATUS_RANGE, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_FREE, 2, 255, 0, '0, TYPED,
			msiva_pkg::STATUS_RANGE, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_FREE, 0, 3, 0, '0, TYPED,
			msiva_pkg::STATUS_RANGE, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ASSIGN, 0, 256, 2, '0, TYPED,
			msiva_pkg::STATUS_RANGE, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ASSIGN, 0, 4095, 5, '0, TYPED,
			msiva_pkg::STATUS_RANGE, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ALLOC, 256, 0, 0, '0, BY_MODEL,
			msiva_pkg::STATUS_OK, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_FREE, 1, 4095, 0, '0, TYPED,
			msiva_pkg::STATUS_RANGE, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ASSIGN, 0, 255, 3, '0, TYPED,
			msiva_pkg::STATUS_OK, 3));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_FREE, 1, 255, 0, '0, TYPED,
			msiva_pkg::STATUS_OK, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_ALLOC, 1, 0, 0, '0, BY_MODEL,
			msiva_pkg::STATUS_OK, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_FREE, 256, 0, 0, '0, TYPED,
			msiva_pkg::STATUS_OK, 0));
		directed_requests.push_back(dir_row(msiva_pkg::CMD_LOAD, 0, 0, 3, 56'h5A_C3F0_0FC3_A55A,
			TYPED, msiva_pkg::STATUS_OK, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < directed_requests.size(); r++)
			send_request(directed_requests[r].req, directed_requests[r].typed,
				directed_requests[r].res, r == directed_requests.size() - 1, model_res);

		// Random phases, each under its own register settings
		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			fv_pick = (phase_fv[ph] < 0) ? $urandom_range(0, 2047) : phase_fv[ph];
			vc_pick = (phase_vc[ph] < 0) ?
				($urandom_range(1, 256) + ($urandom_range(3) << VC_W)) : phase_vc[ph];
			write_regs(CFG_DAT_W'(fv_pick), CFG_DAT_W'(vc_pick));
			live_run_base.delete();
			live_run_len.delete();
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k == 0) begin
					// start from a clear map
					make_request(req);
					req.command = msiva_pkg::CMD_FREE;
					req.vector = VECTOR_W'(first_vec);
					req.count = COUNT_W'(live_depth());
				end else begin
					make_request(req);
				end
				if (ph == 0 && k == HOLD_AT)
					hold_requests++;
				pause_here = (ph == 1 && k == PAUSE_AT);
				send_request(req, BY_MODEL, '0, pause_here || k == ITEMS_PER_PHASE - 1, model_res);
				if (req.command == msiva_pkg::CMD_ALLOC &&
					model_res.status == msiva_pkg::STATUS_OK) begin
					live_run_base.push_back(int'(model_res.message_data) - 1);
					live_run_len.push_back(int'(req.count));
				end
				if (pause_here)
					wait_drained();
			end
		end

		// Drain, then watch for stray beats
		while (pending_results.size() != 0) @(posedge clk);
		repeat (END_SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
